### hw/rtl/hbsi_pkg.sv
// ----------------------------------------------------------------------------
// Halo border source index: shared definitions
// Field widths, register codes and the halo depth used across the block.
// ----------------------------------------------------------------------------
package hbsi_pkg;

	localparam int IDX_W     = 25;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int HALO      = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXTENT_X,
		REG_EXTENT_Y,
		REG_EXTENT_Z,
		REG_EXTENT_W
	} cfg_reg_t;

endpackage

### hw/rtl/hbsi_cfg.sv
// ----------------------------------------------------------------------------
// Halo border source index: geometry registers
// Holds the four extents and derives the padded sizes and the volume.
// ----------------------------------------------------------------------------
module hbsi_cfg #(
	parameter int MAX_EXTENT = 64,
	parameter int EW         = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  hbsi_pkg::cfg_reg_t          wr_index,
	input  logic [hbsi_pkg::CFG_W-1:0]  wr_data,
	output logic [EW-1:0]               d0,
	output logic [EW-1:0]               d1,
	output logic [EW-1:0]               d2,
	output logic [EW-1:0]               d3,
	output logic [EW-1:0]               e1,
	output logic [EW-1:0]               e2,
	output logic [EW-1:0]               hd0,
	output logic [4*EW-1:0]             vol
);

	localparam int CAP0 = (MAX_EXTENT / 2) * 2;
	localparam int CAP  = (CAP0 < 2) ? 2 : CAP0;

	logic [hbsi_pkg::CFG_W-1:0] ext_q [4];
	logic [EW-1:0]              d_q [4];
	logic [EW-1:0]              e_w [4];
	logic [2*EW-1:0]            p01_q;
	logic [2*EW-1:0]            p23_q;
	logic [4*EW-1:0]            vol_q;

	function automatic logic [EW-1:0] eff(input logic [hbsi_pkg::CFG_W-1:0] v);
		int e;
		e = int'({v[hbsi_pkg::CFG_W-1:1], 1'b0});
		if (e < 2) e = 2;
		if (e > CAP) e = CAP;
		return EW'(e);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) ext_q[i] <= hbsi_pkg::CFG_W'(2);
		end else if (wr_en) begin
			case (wr_index)
				hbsi_pkg::REG_EXTENT_X: ext_q[0] <= wr_data;
				hbsi_pkg::REG_EXTENT_Y: ext_q[1] <= wr_data;
				hbsi_pkg::REG_EXTENT_Z: ext_q[2] <= wr_data;
				hbsi_pkg::REG_EXTENT_W: ext_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) e_w[i] = d_q[i] + EW'(4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) d_q[i] <= EW'(2);
			p01_q <= (2*EW)'(36);
			p23_q <= (2*EW)'(36);
			vol_q <= (4*EW)'(1296);
		end else begin
			for (int i = 0; i < 4; i++) d_q[i] <= eff(ext_q[i]);
			p01_q <= (2*EW)'(e_w[0]) * (2*EW)'(e_w[1]);
			p23_q <= (2*EW)'(e_w[2]) * (2*EW)'(e_w[3]);
			vol_q <= (4*EW)'(p01_q) * (4*EW)'(p23_q);
		end
	end

	assign d0  = d_q[0];
	assign d1  = d_q[1];
	assign d2  = d_q[2];
	assign d3  = d_q[3];
	assign e1  = e_w[1];
	assign e2  = e_w[2];
	assign hd0 = e_w[0] >> 1;
	assign vol = vol_q;

endmodule

### hw/rtl/hbsi_div.sv
// ----------------------------------------------------------------------------
// Halo border source index: pipelined divider
// Restoring division, a few quotient bits per stage, with sideband data.
// ----------------------------------------------------------------------------
module hbsi_div #(
	parameter int NW  = 25,
	parameter int DW  = 7,
	parameter int SW  = 1,
	parameter int BPS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] dvs,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [SW-1:0] out_side
);

	localparam int NST = (NW + BPS - 1) / BPS;
	localparam int TW  = NST * BPS;

	logic [DW-1:0] rem_s  [NST];
	logic [TW-1:0] nq_s   [NST];
	logic          v_s    [NST];
	logic [SW-1:0] side_s [NST];

	for (genvar g = 0; g < NST; g++) begin : g_st
		logic [DW-1:0] rem_in;
		logic [TW-1:0] nq_in;
		logic          v_in;
		logic [SW-1:0] side_in;
		logic [DW-1:0] rem_nx;
		logic [TW-1:0] nq_nx;

		if (g == 0) begin : g_first
			assign rem_in  = '0;
			assign nq_in   = TW'(num);
			assign v_in    = in_valid;
			assign side_in = in_side;
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign nq_in   = nq_s[g-1];
			assign v_in    = v_s[g-1];
			assign side_in = side_s[g-1];
		end

		always_comb begin
			logic [DW:0] t;
			rem_nx = rem_in;
			nq_nx  = nq_in;
			for (int k = 0; k < BPS; k++) begin
				t     = {rem_nx, nq_nx[TW-1]};
				nq_nx = {nq_nx[TW-2:0], 1'b0};
				if (t >= {1'b0, dvs}) begin
					t        = t - {1'b0, dvs};
					nq_nx[0] = 1'b1;
				end
				rem_nx = t[DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= rem_nx;
				nq_s[g]   <= nq_nx;
				side_s[g] <= side_in;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign quo       = nq_s[NST-1][NW-1:0];
	assign rem       = rem_s[NST-1];
	assign out_side  = side_s[NST-1];

endmodule

### hw/rtl/hbsi_map.sv
// ----------------------------------------------------------------------------
// Halo border source index: wrap and re-encode
// Folds halo coordinates into the interior and rebuilds the checkerboard index.
// ----------------------------------------------------------------------------
module hbsi_map #(
	parameter int EW = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [hbsi_pkg::IDX_W-1:0] idx,
	input  logic                       oor,
	input  logic                       odd,
	input  logic [EW-1:0]              x1h,
	input  logic [EW-1:0]              x2,
	input  logic [EW-1:0]              x3,
	input  logic [EW-1:0]              x4,
	input  logic [EW-1:0]              d0,
	input  logic [EW-1:0]              d1,
	input  logic [EW-1:0]              d2,
	input  logic [EW-1:0]              d3,
	input  logic [EW-1:0]              e1,
	input  logic [EW-1:0]              e2,
	input  logic [EW-1:0]              hd0,
	input  logic [4*EW-1:0]            vol,
	output logic                       out_valid,
	output logic                       is_border,
	output logic                       out_of_range,
	output logic [hbsi_pkg::IDX_W-1:0] source_index
);

	localparam int CW   = EW + 1;
	localparam int M1W  = 2 * EW;
	localparam int M2W  = 3 * EW;
	localparam int M3W  = 4 * EW;
	localparam int SUMW = (M3W + 1 > hbsi_pkg::IDX_W) ? M3W + 1 : hbsi_pkg::IDX_W;

	function automatic logic [CW-1:0] wrap(input logic [CW-1:0] c, input logic [EW-1:0] d);
		logic [CW-1:0] dw;
		dw = {1'b0, d};
		if (c < CW'(hbsi_pkg::HALO)) return c + dw;
		if (c > dw + CW'(1)) return c - dw;
		return c;
	endfunction

	function automatic logic in_halo(input logic [CW-1:0] c, input logic [EW-1:0] d);
		return (c < CW'(hbsi_pkg::HALO)) || (c > {1'b0, d} + CW'(1));
	endfunction

	logic [CW-1:0] c1, c2, c3, c4;
	logic [CW-1:0] y1;

	logic                       v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [hbsi_pkg::IDX_W-1:0] idx_s3, idx_s4, idx_s5, idx_s6, src_s7;
	logic                       oor_s3, oor_s4, oor_s5, oor_s6, oor_s7;
	logic                       odd_s3, odd_s4, odd_s5, odd_s6;
	logic                       bd_s3, bd_s4, bd_s5, bd_s6, bd_s7;
	logic [EW-1:0]              y1h_s3, y1h_s4, y1h_s5;
	logic [EW-1:0]              y2_s3, y2_s4;
	logic [EW-1:0]              y3_s3, y4_s3;
	logic [M1W-1:0]             m1_s4;
	logic [M2W-1:0]             m2_s5;
	logic [M3W-1:0]             m3_s6;
	logic [SUMW-1:0]            sum;

	assign c1 = {x1h, x2[0] ^ x3[0] ^ x4[0] ^ odd};
	assign c2 = {1'b0, x2};
	assign c3 = {1'b0, x3};
	assign c4 = {1'b0, x4};
	assign y1 = wrap(c1, d0);
	assign sum = SUMW'(m3_s6) + (odd_s6 ? SUMW'(vol >> 1) : SUMW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3 <= idx;
			oor_s3 <= oor;
			odd_s3 <= odd;
			bd_s3  <= !oor && (in_halo(c1, d0) || in_halo(c2, d1) ||
				in_halo(c3, d2) || in_halo(c4, d3));
			y1h_s3 <= y1[CW-1:1];
			y2_s3  <= EW'(wrap(c2, d1));
			y3_s3  <= EW'(wrap(c3, d2));
			y4_s3  <= EW'(wrap(c4, d3));

			idx_s4 <= idx_s3;
			oor_s4 <= oor_s3;
			odd_s4 <= odd_s3;
			bd_s4  <= bd_s3;
			y1h_s4 <= y1h_s3;
			y2_s4  <= y2_s3;
			m1_s4  <= M1W'(y4_s3) * M1W'(e2) + M1W'(y3_s3);

			idx_s5 <= idx_s4;
			oor_s5 <= oor_s4;
			odd_s5 <= odd_s4;
			bd_s5  <= bd_s4;
			y1h_s5 <= y1h_s4;
			m2_s5  <= M2W'(m1_s4) * M2W'(e1) + M2W'(y2_s4);

			idx_s6 <= idx_s5;
			oor_s6 <= oor_s5;
			odd_s6 <= odd_s5;
			bd_s6  <= bd_s5;
			m3_s6  <= M3W'(m2_s5) * M3W'(hd0) + M3W'(y1h_s5);

			oor_s7 <= oor_s6;
			bd_s7  <= bd_s6;
			src_s7 <= bd_s6 ? sum[hbsi_pkg::IDX_W-1:0] : idx_s6;
		end
	end

	assign out_valid    = v_s7;
	assign is_border    = bd_s7;
	assign out_of_range = oor_s7;
	assign source_index = src_s7;

endmodule

### hw/rtl/halo_border_source_index.sv
// ----------------------------------------------------------------------------
// Halo border source index
// Decodes a padded checkerboard site index and gives the halo source index.
// ----------------------------------------------------------------------------
// An item passes through 24 register stages: two input stages, seventeen
// divider stages (four quotient bits each) and five wrap and multiply stages,
// at MAX_EXTENT of 64. One item is accepted every cycle; the whole pipeline
// holds when the output item is not taken. After a register write, derived
// geometry passes the extent, size, partial product and volume registers.
// Reset clears all valid bits and sets every extent to 2.
// ----------------------------------------------------------------------------
module halo_border_source_index #(
	parameter int MAX_EXTENT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // site_index
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // source_index
	output logic [1:0]                    m_tuser,   // [1] out_of_range, [0] is_border
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hbsi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hbsi_pkg::CFG_W-1:0]    cfg_data
);

	localparam int EW  = $clog2(MAX_EXTENT + 5);
	localparam int VW  = 4 * EW;
	localparam int IW  = hbsi_pkg::IDX_W;
	localparam int MW  = (VW > IW) ? VW : IW;
	localparam int NB  = 3 * EW;
	localparam int NC  = 2 * EW;
	localparam int SWA = IW + 2;
	localparam int SWB = SWA + EW;
	localparam int SWC = SWB + EW;

	logic en;
	logic [EW-1:0] d0, d1, d2, d3, e1, e2, hd0;
	logic [VW-1:0] vol;

	logic          v_s1, v_s2;
	logic [IW-1:0] idx_s1, idx_s2, site_s2;
	logic          oor_s2, odd_s2;
	logic [MW-1:0] idx_w, vol_w, half_w;

	logic           va, vb, vc;
	logic [IW-1:0]  qa;
	logic [NB-1:0]  qb;
	logic [NC-1:0]  qc;
	logic [EW-1:0]  ra, rb, rc;
	logic [SWA-1:0] sa;
	logic [SWB-1:0] sb;
	logic [SWC-1:0] sc;

	logic          bd, oor_o;
	logic [IW-1:0] src;

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	hbsi_cfg #(.MAX_EXTENT(MAX_EXTENT), .EW(EW)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (hbsi_pkg::cfg_reg_t'(cfg_index)),
		.wr_data  (cfg_data),
		.d0       (d0),
		.d1       (d1),
		.d2       (d2),
		.d3       (d3),
		.e1       (e1),
		.e2       (e2),
		.hd0      (hd0),
		.vol      (vol)
	);

	assign idx_w  = MW'(idx_s1);
	assign vol_w  = MW'(vol);
	assign half_w = vol_w >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= s_tdata[IW-1:0];
			idx_s2  <= idx_s1;
			oor_s2  <= idx_w >= vol_w;
			odd_s2  <= idx_w >= half_w;
			site_s2 <= (idx_w >= half_w) ? IW'(idx_w - half_w) : idx_s1;
		end
	end

	hbsi_div #(.NW(IW), .DW(EW), .SW(SWA)) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       (site_s2),
		.dvs       (hd0),
		.in_side   ({idx_s2, oor_s2, odd_s2}),
		.out_valid (va),
		.quo       (qa),
		.rem       (ra),
		.out_side  (sa)
	);

	hbsi_div #(.NW(NB), .DW(EW), .SW(SWB)) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (va),
		.num       (NB'(qa)),
		.dvs       (e1),
		.in_side   ({sa, ra}),
		.out_valid (vb),
		.quo       (qb),
		.rem       (rb),
		.out_side  (sb)
	);

	hbsi_div #(.NW(NC), .DW(EW), .SW(SWC)) u_div_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vb),
		.num       (NC'(qb)),
		.dvs       (e2),
		.in_side   ({sb, rb}),
		.out_valid (vc),
		.quo       (qc),
		.rem       (rc),
		.out_side  (sc)
	);

	hbsi_map #(.EW(EW)) u_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (vc),
		.idx          (sc[SWC-1 -: IW]),
		.oor          (sc[2*EW+1]),
		.odd          (sc[2*EW]),
		.x1h          (sc[2*EW-1 -: EW]),
		.x2           (sc[EW-1:0]),
		.x3           (rc),
		.x4           (EW'(qc)),
		.d0           (d0),
		.d1           (d1),
		.d2           (d2),
		.d3           (d3),
		.e1           (e1),
		.e2           (e2),
		.hd0          (hd0),
		.vol          (vol),
		.out_valid    (m_tvalid),
		.is_border    (bd),
		.out_of_range (oor_o),
		.source_index (src)
	);

	assign m_tdata = {{(32 - IW){1'b0}}, src};
	assign m_tuser = {oor_o, bd};

endmodule

### hw/rtl/hbsi_chk.sv
// ----------------------------------------------------------------------------
// Halo border source index: port checker
// Watches the ports of the top level for stall, flag and padding consistency.
// ----------------------------------------------------------------------------
module hbsi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Output item changed while stalled.");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("Input taken while the pipeline is stalled.");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("Out-of-range item flagged as halo.");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:25] == 7'd0)
		else $error("Padding bits of the output item are not zero.");

endmodule

bind halo_border_source_index hbsi_chk u_hbsi_chk (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Halo border source index testbench
// Drives padded checkerboard site indices through the stream port, predicts
// halo flag, source index and range flag, and checks every output item in
// order while both sides idle at random and the extents change between phases.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXE = 64;
	localparam int LATENCY = 24;
	localparam longint LIMIT = 400000;

	typedef struct packed {
		logic                       border;
		logic [hbsi_pkg::IDX_W-1:0] source;
		logic                       oor;
	} halo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hbsi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hbsi_pkg::CFG_W-1:0] cfg_data = '0;

	logic [hbsi_pkg::CFG_W-1:0] extents [4];
	halo_result_t expected_q [$];
	int errors = 0;
	longint cycles = 0;
	int send_idle_pct = 15;
	int recv_idle_pct = 15;
	int hold_off = 0;
	int hold_req = 0;
	int hold_ack = 0;

	halo_border_source_index #(.MAX_EXTENT(MAXE)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint effective_extent(logic [hbsi_pkg::CFG_W-1:0] v);
		longint e;
		e = longint'(v) & ~longint'(1);
		if (e < 2) e = 2;
		if (e > MAXE) e = MAXE;
		return e;
	endfunction

	function automatic longint padded_volume();
		longint v;
		v = 1;
		for (int a = 0; a < 4; a++) v *= effective_extent(extents[a]) + 4;
		return v;
	endfunction

	function automatic halo_result_t halo_source(logic [hbsi_pkg::IDX_W-1:0] idx);
		halo_result_t r;
		longint d [4];
		longint e [4];
		longint c [4];
		longint vol, half, hx, site, odd, rest, src;
		logic border;
		for (int a = 0; a < 4; a++) begin
			d[a] = effective_extent(extents[a]);
			e[a] = d[a] + 4;
		end
		vol = e[0] * e[1] * e[2] * e[3];
		half = vol / 2;
		hx = e[0] / 2;
		r = '0;
		if (longint'(idx) >= vol) begin
			r.source = idx;
			r.oor = 1'b1;
			return r;
		end
		odd = (longint'(idx) >= half) ? 1 : 0;
		site = longint'(idx) - odd * half;
		rest = site / hx;
		c[1] = rest % e[1];
		rest = rest / e[1];
		c[2] = rest % e[2];
		c[3] = rest / e[2];
		c[0] = 2 * (site % hx) + ((c[1] + c[2] + c[3] + odd) & 1);
		border = 1'b0;
		for (int a = 0; a < 4; a++) begin
			if (c[a] < hbsi_pkg::HALO || c[a] > d[a] + 1) begin
				border = 1'b1;
				c[a] = hbsi_pkg::HALO + ((c[a] + d[a] - hbsi_pkg::HALO) % d[a]);
			end
		end
		src = border ? ((c[3] * e[2] + c[2]) * e[1] + c[1]) * hx + (c[0] >> 1) + odd * half
			: longint'(idx);
		r.border = border;
		r.source = src[hbsi_pkg::IDX_W-1:0];
		return r;
	endfunction

	task automatic send_site(logic [hbsi_pkg::IDX_W-1:0] idx);
		int idle;
		idle = 0;
		while ($urandom_range(99) < send_idle_pct) idle++;
		if (idle > 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= 32'(idx);
		expected_q.push_back(halo_source(idx));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_extent(hbsi_pkg::cfg_reg_t r, logic [hbsi_pkg::CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		extents[r] = v;
		repeat (6) @(posedge clk);
	endtask

	task automatic set_extents(logic [hbsi_pkg::CFG_W-1:0] x, logic [hbsi_pkg::CFG_W-1:0] y,
			logic [hbsi_pkg::CFG_W-1:0] z, logic [hbsi_pkg::CFG_W-1:0] w);
		drain();
		write_extent(hbsi_pkg::REG_EXTENT_X, x);
		write_extent(hbsi_pkg::REG_EXTENT_Y, y);
		write_extent(hbsi_pkg::REG_EXTENT_Z, z);
		write_extent(hbsi_pkg::REG_EXTENT_W, w);
	endtask

	function automatic logic [hbsi_pkg::IDX_W-1:0] random_site();
		longint vol;
		vol = padded_volume();
		case ($urandom_range(9))
			0: return hbsi_pkg::IDX_W'($urandom);
			1: return hbsi_pkg::IDX_W'(vol - 1 + $urandom_range(2));
			default: return hbsi_pkg::IDX_W'($urandom_range(32'(vol - 1)));
		endcase
	endfunction

	task automatic test_directed();
		longint vol;
		foreach (extents[a]) extents[a] = hbsi_pkg::CFG_W'(2);
		vol = padded_volume();
		send_site('0);
		send_site(hbsi_pkg::IDX_W'(1));
		send_site(hbsi_pkg::IDX_W'(vol / 2 - 1));
		send_site(hbsi_pkg::IDX_W'(vol / 2));
		send_site(hbsi_pkg::IDX_W'(vol - 1));
		send_site(hbsi_pkg::IDX_W'(vol));
		send_site('1);
		send_site(hbsi_pkg::IDX_W'(21381375));
		set_extents(7'd64, 7'd64, 7'd64, 7'd64);
		vol = padded_volume();
		send_site('0);
		send_site(hbsi_pkg::IDX_W'(vol / 2 + 1000));
		send_site(hbsi_pkg::IDX_W'(vol - 1));
		send_site(hbsi_pkg::IDX_W'(vol));
		send_site('1);
		set_extents(7'd127, 7'd0, 7'd1, 7'd5);
		vol = padded_volume();
		send_site(hbsi_pkg::IDX_W'(vol - 1));
		send_site(hbsi_pkg::IDX_W'(vol / 2 + 7));
		send_site(hbsi_pkg::IDX_W'(33));
		send_site(hbsi_pkg::IDX_W'(vol));
	endtask

	task automatic test_random_geometries();
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 0) set_extents(7'd2, 7'd2, 7'd2, 7'd2);
			else if (phase == 1) set_extents(7'd64, 7'd2, 7'd64, 7'd2);
			else set_extents(hbsi_pkg::CFG_W'($urandom_range(1, 70)),
				hbsi_pkg::CFG_W'($urandom_range(1, 70)),
				hbsi_pkg::CFG_W'($urandom_range(1, 70)),
				hbsi_pkg::CFG_W'($urandom_range(1, 70)));
			send_idle_pct = (phase == 3) ? 0 : 15;
			recv_idle_pct = (phase == 3) ? 0 : 15;
			repeat (75) send_site(random_site());
		end
		send_idle_pct = 15;
		recv_idle_pct = 15;
	endtask

	task automatic test_backpressure();
		set_extents(7'd10, 7'd6, 7'd4, 7'd8);
		hold_req++;
		repeat (80) send_site(random_site());
		drain();
		repeat (50) send_site(random_site());
	endtask

	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_off <= 200;
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		halo_result_t want;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("halo_border_source_index regression: fail");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected item: source_index %0d", m_tdata[hbsi_pkg::IDX_W-1:0]);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (m_tuser[0] !== want.border) begin
					$error("is_border expected %0d actual %0d", want.border, m_tuser[0]);
					errors++;
				end
				if (m_tdata[hbsi_pkg::IDX_W-1:0] !== want.source) begin
					$error("source_index expected %0d actual %0d", want.source,
						m_tdata[hbsi_pkg::IDX_W-1:0]);
					errors++;
				end
				if (m_tuser[1] !== want.oor) begin
					$error("out_of_range expected %0d actual %0d", want.oor, m_tuser[1]);
					errors++;
				end
			end
		end
	end

	initial begin
		foreach (extents[a]) extents[a] = hbsi_pkg::CFG_W'(2);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_geometries();
		test_backpressure();
		drain();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("halo_border_source_index regression: pass");
		end else begin
			$display("halo_border_source_index regression: fail");
		end
		$finish;
	end
endmodule
